### src/hla_pkg.sv
// package for the hough line accumulator: widths, op codes, shared types
`default_nettype none
package hla_pkg;
   localparam int ThetaBins = 256;
   localparam int RBins = 256;
   localparam int ChamberCount = 64;
   localparam int ThetaW = $clog2(ThetaBins);
   localparam int RW = $clog2(RBins);
   localparam int AddrW = ThetaW + RW;
   localparam int Depth = ThetaBins * RBins;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_ADD   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_THETA_COUNT = 2'd0,
      CSR_R_COUNT     = 2'd1,
      CSR_R_MIN       = 2'd2,
      CSR_R_INV       = 2'd3
   } csr_type;

   typedef struct packed {
      logic        wr;
      logic [AddrW-1:0] addr;
      logic [15:0] votes;
      logic [63:0] mask;
   } mem_wr_type;
endpackage
`default_nettype wire

### src/hla_bin_store.sv
// vote and chamber mask memory, one write port and one registered read port
`default_nettype none
module hla_bin_store (
   input  wire logic                      clock,
   input  wire hla_pkg::mem_wr_type       wr,
   input  wire logic [hla_pkg::AddrW-1:0] rd_addr,
   output logic [15:0]                    rd_votes,
   output logic [63:0]                    rd_mask
);
   import hla_pkg::*;
   logic [79:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr.wr) begin
         mem[wr.addr] <= {wr.mask, wr.votes};
      end
      {rd_mask, rd_votes} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/hough_line_accumulator.sv
// top level: sequencer over theta bins doing read-modify-write of the bin store
// The time a word takes depends on its op. Add point: trig read, multiply, bin,
// then read-modify-write per active theta bin through the bin store; straight to
// the result when either bin count is zero. Read: centre, eight neighbor reads,
// then a chamber-run scan over 64 bits in eight-bit steps. Clear: writes every
// bin, one store row per cycle. A result that is not taken holds the block in
// its output state. After reset the block runs a clearing pass before it takes
// the first word.
`default_nettype none
module hough_line_accumulator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op, z_coord, x_coord, chamber, theta_index, r_index, sin_value, cos_value, min_votes
   input  wire logic [111:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // vote_max, bin_votes, peak_votes, run_length, first_chamber, last_chamber
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);
   import hla_pkg::*;

   typedef enum logic [9:0] {
      S_INIT  = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_TRIG  = 10'b0000000100,
      S_MUL   = 10'b0000001000,
      S_BIN   = 10'b0000010000,
      S_RMW   = 10'b0000100000,
      S_WB    = 10'b0001000000,
      S_RD    = 10'b0010000000,
      S_RUN   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [8:0] theta_cnt_ff, r_cnt_ff;
   logic signed [15:0] r_min_ff;
   logic [23:0] r_inv_ff;
   logic [17:0] sin_mem [ThetaBins];
   logic [17:0] cos_mem [ThetaBins];
   logic signed [17:0] sin_rd_ff, cos_rd_ff;

   logic [1:0] op_ff;
   logic signed [15:0] z_ff, x_ff;
   logic [5:0] ch_ff;
   logic [ThetaW-1:0] ti_ff;
   logic [RW-1:0] ri_ff;
   logic [15:0] minv_ff;
   logic [AddrW:0] cnt_ff;
   logic signed [34:0] pz_ff, px_ff;
   logic [AddrW-1:0] addr_ff;
   logic hit_ff;
   logic [15:0] vmax_ff, bv_ff;
   logic nb_max_ff;
   logic peak_ok_ff;
   logic [63:0] mask_ff;
   logic [6:0] run_ff, best_ff;
   logic [5:0] end_ff;
   logic [3:0] nb_ff;
   logic [71:0] out_ff, out_in;
   logic out_v_ff;

   mem_wr_type wr;
   logic [AddrW-1:0] rd_addr;
   logic [15:0] rd_votes;
   logic [63:0] rd_mask;

   hla_bin_store u_store (.clock, .wr, .rd_addr, .rd_votes, .rd_mask);

   logic [8:0] nt, nr;
   assign nt = (theta_cnt_ff > 9'(ThetaBins)) ? 9'(ThetaBins) : theta_cnt_ff;
   assign nr = (r_cnt_ff > 9'(RBins)) ? 9'(RBins) : r_cnt_ff;

   // bin computation
   logic signed [37:0] rsum, dsum;
   logic [56:0] prod;
   logic [20:0] binv;
   assign rsum = 38'(pz_ff) + 38'(px_ff);
   assign dsum = rsum - {{6{r_min_ff[15]}}, r_min_ff, 16'd0};
   assign prod = 57'(dsum[32:0]) * 57'(r_inv_ff);
   assign binv = prod[56:36];

   // neighbor offsets
   logic signed [9:0] nbt, nbr, dto, dro;
   logic nb_in;
   always_comb begin
      case (nb_ff)
         4'd0, 4'd1, 4'd2: dto = 10'sd1;
         4'd3, 4'd4, 4'd5: dto = 10'sd0;
         default: dto = -10'sd1;
      endcase
      case (nb_ff)
         4'd0, 4'd3, 4'd6: dro = 10'sd1;
         4'd1, 4'd4, 4'd7: dro = 10'sd0;
         default: dro = -10'sd1;
      endcase
      nbt = $signed({2'b0, ti_ff}) + dto;
      nbr = $signed({2'b0, ri_ff}) + dro;
      nb_in = (nbt >= 0) && (nbt < $signed({1'b0, nt})) &&
              (nbr >= 0) && (nbr < $signed({1'b0, nr}));
   end

   logic [15:0] vinc;
   logic [63:0] mnew;
   assign vinc = (rd_votes == 16'hFFFF) ? rd_votes : rd_votes + 16'd1;
   assign mnew = rd_mask | (64'd1 << ch_ff);

   // run scan, eight chambers a step
   logic [6:0] run_n, best_n;
   logic [5:0] end_n;
   always_comb begin
      run_n = run_ff; best_n = best_ff; end_n = end_ff;
      for (int k = 0; k < 8; k++) begin
         if (mask_ff[{cnt_ff[2:0], 3'(k)}]) begin
            run_n = run_n + 7'd1;
            if (run_n >= best_n) begin
               best_n = run_n; end_n = {cnt_ff[2:0], 3'(k)};
            end
         end else begin
            run_n = 7'd0;
         end
      end
   end

   always_comb begin
      wr = '0;
      rd_addr = addr_ff;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            wr.wr = 1'b1; wr.addr = cnt_ff[AddrW-1:0];
            if (cnt_ff[AddrW-1:0] == '1)
               state_in = (op_type'(op_ff) == OP_CLEAR) ? S_OUT : S_IDLE;
         end
         S_IDLE: if (req_tvalid) begin
            case (op_type'(req_tdata[1:0]))
               OP_CLEAR: state_in = S_INIT;
               OP_LOAD: state_in = S_OUT;
               OP_ADD: state_in = (nt == 9'd0 || nr == 9'd0) ? S_OUT : S_TRIG;
               OP_READ: begin
                  state_in = S_RD;
                  rd_addr = {req_tdata[47:40], req_tdata[55:48]};
               end
               default: state_in = S_OUT;
            endcase
         end
         S_TRIG: state_in = S_MUL;
         S_MUL: state_in = S_BIN;
         S_BIN: state_in = S_RMW;
         S_RMW: state_in = S_WB;
         S_WB: begin
            wr.wr = hit_ff; wr.addr = addr_ff; wr.votes = vinc;
            wr.mask = mnew;
            state_in = (cnt_ff[8:0] + 9'd1 >= nt) ? S_OUT : S_TRIG;
         end
         S_RD: begin
            rd_addr = {nbt[ThetaW-1:0], nbr[RW-1:0]};
            if (nb_ff == 4'd9) state_in = S_RUN;
         end
         S_RUN: if (cnt_ff[2:0] == 3'd7) state_in = S_OUT;
         S_OUT: if (!out_v_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid && op_type'(req_tdata[1:0]) == OP_LOAD) begin
         sin_mem[req_tdata[47:40]] <= req_tdata[73:56];
         cos_mem[req_tdata[47:40]] <= req_tdata[91:74];
      end
      sin_rd_ff <= sin_mem[cnt_ff[ThetaW-1:0]];
      cos_rd_ff <= cos_mem[cnt_ff[ThetaW-1:0]];
      pz_ff <= z_ff * cos_rd_ff;
      px_ff <= x_ff * sin_rd_ff;
      if (state_ff == S_BIN) begin
         hit_ff <= !dsum[37] && dsum[36:33] == 4'd0 ? (binv < 21'(nr)) : 1'b0;
         addr_ff <= {cnt_ff[ThetaW-1:0], binv[RW-1:0]};
      end
      if (state_ff == S_IDLE) begin
         z_ff <= req_tdata[17:2];
         x_ff <= req_tdata[33:18];
         ch_ff <= req_tdata[39:34];
         ti_ff <= req_tdata[47:40];
         ri_ff <= req_tdata[55:48];
         minv_ff <= req_tdata[107:92];
         addr_ff <= {req_tdata[47:40], req_tdata[55:48]};
         nb_ff <= 4'd0;
         peak_ok_ff <= 1'b1;
         run_ff <= '0; best_ff <= '0; end_ff <= '0;
      end
      if (state_ff == S_RD) begin
         nb_ff <= nb_ff + 4'd1;
         if (nb_ff == 4'd0) begin
            bv_ff <= rd_votes; mask_ff <= rd_mask;
         end else if (nb_ff != 4'd0 && rd_votes > bv_ff && nb_max_ff)
            peak_ok_ff <= 1'b0;
         nb_max_ff <= nb_in;
      end
      if (state_ff == S_RUN) begin
         run_ff <= run_n; best_ff <= best_n; end_ff <= end_n;
      end
   end

   logic read_ok;
   assign read_ok = (9'(ti_ff) < nt) && (9'(ri_ff) < nr);

   always_comb begin
      out_in = '0;
      out_in[15:0] = vmax_ff;
      if (op_type'(op_ff) == OP_READ && read_ok) begin
         out_in[31:16] = bv_ff;
         out_in[47:32] = (peak_ok_ff && !(minv_ff != 16'd0 && bv_ff < minv_ff))
                         ? bv_ff : 16'd0;
         if (best_ff >= 7'd5) begin
            out_in[54:48] = best_ff;
            out_in[60:55] = 6'(7'(end_ff) + 7'd1 - best_ff);
            out_in[66:61] = end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= '0;
         vmax_ff <= '0;
         out_v_ff <= 1'b0;
         op_ff <= OP_LOAD;
         theta_cnt_ff <= 9'd256; r_cnt_ff <= 9'd256;
         r_min_ff <= 16'sh8000; r_inv_ff <= 24'd65536;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_THETA_COUNT: theta_cnt_ff <= csr_wdata[8:0];
               CSR_R_COUNT: r_cnt_ff <= csr_wdata[8:0];
               CSR_R_MIN: r_min_ff <= csr_wdata[15:0];
               CSR_R_INV: r_inv_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_OUT && state_in == S_IDLE) begin
            out_v_ff <= 1'b1;
            out_ff <= out_in;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: cnt_ff <= (state_in != S_INIT) ? '0 : cnt_ff + 1'b1;
            S_IDLE: begin
               cnt_ff <= '0;
               op_ff <= req_tdata[1:0];
               if (req_tvalid && op_type'(req_tdata[1:0]) == OP_CLEAR) vmax_ff <= '0;
            end
            S_WB: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (hit_ff && vinc > vmax_ff) vmax_ff <= vinc;
            end
            S_RD: cnt_ff <= '0;
            S_RUN: cnt_ff <= cnt_ff + 1'b1;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = out_ff;

   a_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && hit_ff) |-> (vinc >= rd_votes)) else $error("vote went down");
   a_max: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && hit_ff) |=> (vmax_ff >= $past(vinc))) else $error("max missed");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
endmodule
`default_nettype wire
